// File: hw/rtl/hbp_pkg.sv
package hbp_pkg;

  localparam int MAX_CODE_LEN = 16;
  localparam int SYMBOL_COUNT = 256;

  localparam int KIND_W  = 2;
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 16;
  localparam int LEN_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int PEND_W  = 7;
  localparam int CNT_W   = 3;
  localparam int ACC_W   = CODE_W + PEND_W;

  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic              is_flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } op_t;

endpackage

// File: hw/rtl/hbp_item_if.sv
interface hbp_item_if;
  logic                        valid;
  logic                        ready;
  logic [hbp_pkg::KIND_W-1:0]  kind;
  logic [hbp_pkg::SYM_W-1:0]   symbol;
  logic [hbp_pkg::CODE_W-1:0]  code_value;
  logic [hbp_pkg::LEN_W-1:0]   code_len;

  modport source (output valid, kind, symbol, code_value, code_len, input ready);
  modport sink (input valid, kind, symbol, code_value, code_len, output ready);
endinterface

// File: hw/rtl/hbp_result_if.sv
interface hbp_result_if;
  logic                        valid;
  logic                        ready;
  logic [hbp_pkg::BYTE_W-1:0]  out_byte;
  logic                        last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

// File: hw/rtl/hbp_front.sv
module hbp_front (
  input  logic          clk,
  input  logic          rst,
  hbp_item_if.sink      item,
  output logic          push,
  output hbp_pkg::op_t  push_op,
  input  logic          full
);
  import hbp_pkg::*;

  entry_t                  mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld;

  logic              s1_valid;
  logic              s1_flush;
  entry_t            rd_data;
  logic              rd_vld;

  logic              sym_ok;
  logic [IDX_W-1:0]  idx;
  logic [LEN_W-1:0]  len_capped;
  logic [CODE_W-1:0] code_masked;
  logic              qualify;
  logic              advance;
  logic              accept;

  assign idx    = item.symbol[IDX_W-1:0];
  assign sym_ok = ({1'b0, item.symbol} < (SYM_W+1)'(SYMBOL_COUNT));

  always_comb begin
    len_capped = (item.code_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : item.code_len;
    if (len_capped < LEN_W'(CODE_W)) begin
      code_masked = item.code_value & ~({CODE_W{1'b1}} << len_capped);
    end else begin
      code_masked = item.code_value;
    end
  end

  assign qualify    = s1_valid && (s1_flush || (rd_vld && (rd_data.len != '0)));
  assign advance    = !s1_valid || !qualify || !full;
  assign item.ready = advance;
  assign accept     = item.valid && advance;
  assign push       = qualify && !full;

  always_comb begin
    push_op.is_flush = s1_flush;
    push_op.code     = rd_data.code;
    push_op.len      = (s1_flush || !rd_vld) ? '0 : rd_data.len;
  end

  always_ff @(posedge clk) begin
    if (accept && (item.kind == KIND_LOAD) && sym_ok) begin
      mem[idx] <= '{code: code_masked, len: len_capped};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (accept && (item.kind == KIND_LOAD) && sym_ok) begin
      vld[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data  <= mem[idx];
      rd_vld   <= vld[idx];
      s1_flush <= (item.kind == KIND_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && (((item.kind == KIND_ENCODE) && sym_ok) ||
                             (item.kind == KIND_FLUSH));
    end
  end

endmodule

// File: hw/rtl/hbp_queue.sv
module hbp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hbp_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output hbp_pkg::op_t  pop_op,
  output logic          empty
);
  import hbp_pkg::*;

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full   = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign pop_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/hbp_back.sv
module hbp_back (
  input  logic          clk,
  input  logic          rst,
  input  hbp_pkg::op_t  op,
  input  logic          empty,
  output logic          pop,
  hbp_result_if.source  result
);
  import hbp_pkg::*;

  logic [PEND_W-1:0] pend_bits;
  logic [CNT_W-1:0]  pend_cnt;
  logic [BYTE_W-1:0] buf_a;
  logic [BYTE_W-1:0] buf_b;
  logic [1:0]        nleft;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  logic              buf_take;
  logic [ACC_W-1:0]  acc;
  logic [LEN_W-1:0]  total;
  logic [BYTE_W-1:0] first;
  logic [BYTE_W-1:0] second;
  logic [1:0]        n;
  logic [PEND_W-1:0] bits_next;
  logic [CNT_W-1:0]  cnt_next;

  assign buf_take = (nleft != '0) && (!out_valid || result.ready);
  assign pop      = !empty && ((nleft == 2'd0) || ((nleft == 2'd1) && buf_take));

  always_comb begin
    acc    = (ACC_W'(pend_bits) << op.len) | ACC_W'(op.code);
    total  = LEN_W'(pend_cnt) + op.len;
    if (op.is_flush) begin
      first     = BYTE_W'({1'b0, pend_bits} << (4'(BYTE_W) - {1'b0, pend_cnt}));
      second    = '0;
      n         = (pend_cnt != '0) ? 2'd1 : 2'd0;
      bits_next = '0;
      cnt_next  = '0;
    end else begin
      first     = BYTE_W'(acc >> (total - LEN_W'(BYTE_W)));
      second    = BYTE_W'(acc >> (total - LEN_W'(2 * BYTE_W)));
      n         = total[LEN_W-1:CNT_W];
      cnt_next  = total[CNT_W-1:0];
      bits_next = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << cnt_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= '0;
      pend_cnt  <= '0;
      nleft     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        pend_bits <= bits_next;
        pend_cnt  <= cnt_next;
        nleft     <= n;
      end else if (buf_take) begin
        nleft <= nleft - 1'b1;
      end
      if (buf_take) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buf_a <= first;
      buf_b <= second;
    end else if (buf_take && (nleft == 2'd2)) begin
      buf_a <= buf_b;
    end
    if (buf_take) begin
      out_byte <= buf_a;
      out_last <= (nleft == 2'd1);
    end
  end

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;
  assign result.last     = out_last;

endmodule

// File: hw/rtl/huffman_table_bit_packer.sv
// Table-driven Huffman encoder that packs codes most significant bit first into
// bytes. Load requests write one entry of a 256-entry code table held in a
// memory with a valid bit per entry, so entries never loaded read as length
// zero straight after reset with no clearing pass. The front end takes one
// request per cycle while the queue is not full, performs the table read in a
// registered stage and places encode and flush work into a four-deep queue;
// loads, empty codes and unused kinds are absorbed there. The back end keeps
// the pending partial byte and emits one byte per cycle through an output
// register while the result port is ready. A symbol giving two bytes holds
// the back end for longer than a flush or a symbol giving at most one byte,
// so the sustained rate is set by the single byte output port and drops for
// streams of long codes.
module huffman_table_bit_packer (
  input  logic          clk,
  input  logic          rst,
  hbp_item_if.sink      item,
  hbp_result_if.source  result
);
  import hbp_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  op_t  q_in;
  op_t  q_out;

  hbp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .push    (q_push),
    .push_op (q_in),
    .full    (q_full)
  );

  hbp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_in),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (q_out),
    .empty   (q_empty)
  );

  hbp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .op     (q_out),
    .empty  (q_empty),
    .pop    (q_pop),
    .result (result)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue read while empty");
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !result.valid)
    else $error("result presented straight after reset");
`endif

endmodule
